@@ hdl/kf2_pkg.sv @@
package kf2_pkg;

   localparam int FracBits = 16;
   localparam int DataW    = 32;
   // dividend width: 32-bit adjugate magnitude scaled by 2^FracBits
   localparam int NumW     = DataW + FracBits;
   localparam int DivCntW  = $clog2(NumW + 1);
   localparam int PcW      = 7;

   localparam logic signed [DataW-1:0] QOne   = DataW'(1) << FracBits;
   localparam logic signed [DataW-1:0] MaxPos = 32'sh7FFF_FFFF;
   localparam logic signed [DataW-1:0] MinNeg = 32'sh8000_0000;

   // request opcodes
   localparam logic [1:0] OpNoise = 2'd0;
   localparam logic [1:0] OpFull  = 2'd1;
   localparam logic [1:0] OpMeas  = 2'd2;
   localparam logic [1:0] OpNone  = 2'd3;

   // csr indexes
   localparam logic [0:0] CsrAccel = 1'b0;
   localparam logic [0:0] CsrVmeas = 1'b1;

   // operand sources: 0..31 register file, 32 and up are fixed sources
   localparam logic [5:0] A_X0  = 6'd0;
   localparam logic [5:0] A_X1  = 6'd1;
   localparam logic [5:0] A_P0  = 6'd2;
   localparam logic [5:0] A_P1  = 6'd3;
   localparam logic [5:0] A_P2  = 6'd4;
   localparam logic [5:0] A_P3  = 6'd5;
   localparam logic [5:0] A_DT  = 6'd6;
   localparam logic [5:0] A_B0  = 6'd7;
   localparam logic [5:0] A_B2  = 6'd8;
   localparam logic [5:0] A_Q0  = 6'd9;
   localparam logic [5:0] A_Q1  = 6'd10;
   localparam logic [5:0] A_Q2  = 6'd11;
   localparam logic [5:0] A_Q3  = 6'd12;
   localparam logic [5:0] A_R0  = 6'd13;
   localparam logic [5:0] A_R1  = 6'd14;
   localparam logic [5:0] A_R3  = 6'd15;
   localparam logic [5:0] A_T0  = 6'd16;
   localparam logic [5:0] A_T1  = 6'd17;
   localparam logic [5:0] A_T2  = 6'd18;
   localparam logic [5:0] A_T3  = 6'd19;
   localparam logic [5:0] A_T4  = 6'd20;
   localparam logic [5:0] A_T5  = 6'd21;
   localparam logic [5:0] A_T6  = 6'd22;
   localparam logic [5:0] A_T7  = 6'd23;
   localparam logic [5:0] A_T8  = 6'd24;
   localparam logic [5:0] A_T9  = 6'd25;
   localparam logic [5:0] A_T10 = 6'd26;
   localparam logic [5:0] A_T11 = 6'd27;
   localparam logic [5:0] A_T12 = 6'd28;
   localparam logic [5:0] A_T13 = 6'd29;
   localparam logic [5:0] A_T14 = 6'd30;
   localparam logic [5:0] A_T15 = 6'd31;
   localparam logic [5:0] A_ZERO = 6'd32;
   localparam logic [5:0] A_ONE  = 6'd33;
   localparam logic [5:0] A_U0   = 6'd34;
   localparam logic [5:0] A_U1   = 6'd35;
   localparam logic [5:0] A_Z0   = 6'd36;
   localparam logic [5:0] A_Z1   = 6'd37;
   localparam logic [5:0] A_TH   = 6'd38;
   localparam logic [5:0] A_DTIN = 6'd39;
   localparam logic [5:0] A_ACC  = 6'd40;

   localparam logic [PcW-1:0] PcNoise = 7'd0;
   localparam logic [PcW-1:0] PcFull  = 7'd25;

   typedef enum logic [3:0] {
      U_ADD, U_SUB, U_MUL, U_SHR1, U_SHR2, U_DIVP, U_DIVN, U_BRZ, U_RET, U_END
   } uop_type;

   typedef struct packed {
      uop_type    uop;
      logic [5:0] src_a;
      logic [5:0] src_b;
      logic [4:0] dst;
   } instr_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_MULW, S_DIV, S_DIVW, S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [30:0]        time_step;
      logic [30:0]        slip_noise;
      logic signed [31:0] ctrl_u0;
      logic signed [31:0] ctrl_u1;
      logic signed [31:0] meas_z0;
      logic signed [31:0] meas_z1;
   } req_type;

   typedef struct packed {
      logic signed [31:0] est_x0;
      logic signed [31:0] est_x1;
      logic               singular_flag;
   } rsp_type;

   function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
      logic signed [DataW-1:0] r;
      if (v > 64'(MaxPos)) r = MaxPos;
      else if (v < 64'(MinNeg)) r = MinNeg;
      else r = v[DataW-1:0];
      return r;
   endfunction

   function automatic instr_type mk(input uop_type u, input logic [5:0] a,
                                    input logic [5:0] b, input logic [5:0] d);
      instr_type r;
      r.uop   = u;
      r.src_a = a;
      r.src_b = b;
      r.dst   = d[4:0];
      return r;
   endfunction

   // microprogram: noise model at 0 (opcode 2 continues past RET),
   // full predict/update at PcFull
   function automatic instr_type prog_rom(input logic [PcW-1:0] pc);
      instr_type r;
      unique case (pc)
         7'd0:  r = mk(U_MUL,  A_TH,   A_TH,   A_R3);
         7'd1:  r = mk(U_ADD,  A_DTIN, A_ZERO, A_DT);
         7'd2:  r = mk(U_MUL,  A_DTIN, A_DTIN, A_T0);
         7'd3:  r = mk(U_SHR2, A_T0,   A_ZERO, A_B0);
         7'd4:  r = mk(U_SHR1, A_DTIN, A_ZERO, A_B2);
         7'd5:  r = mk(U_MUL,  A_B0,   A_ACC,  A_T1);
         7'd6:  r = mk(U_MUL,  A_B2,   A_ACC,  A_T2);
         7'd7:  r = mk(U_MUL,  A_T1,   A_B0,   A_T3);
         7'd8:  r = mk(U_ADD,  A_T3,   A_T3,   A_Q0);
         7'd9:  r = mk(U_MUL,  A_T1,   A_B2,   A_T3);
         7'd10: r = mk(U_ADD,  A_T3,   A_T3,   A_Q1);
         7'd11: r = mk(U_MUL,  A_T2,   A_B0,   A_T3);
         7'd12: r = mk(U_ADD,  A_T3,   A_T3,   A_Q2);
         7'd13: r = mk(U_MUL,  A_T2,   A_B2,   A_T3);
         7'd14: r = mk(U_ADD,  A_T3,   A_T3,   A_Q3);
         7'd15: r = mk(U_MUL,  A_R3,   A_DTIN, A_R1);
         7'd16: r = mk(U_MUL,  A_R1,   A_DTIN, A_R0);
         7'd17: r = mk(U_RET,  A_ZERO, A_ZERO, A_T0);
         7'd18: r = mk(U_ADD,  A_P0,   A_R0,   A_P0);
         7'd19: r = mk(U_ADD,  A_P1,   A_R1,   A_P1);
         7'd20: r = mk(U_ADD,  A_P2,   A_R1,   A_P2);
         7'd21: r = mk(U_ADD,  A_P3,   A_R3,   A_P3);
         7'd22: r = mk(U_ADD,  A_Z0,   A_ZERO, A_X0);
         7'd23: r = mk(U_ADD,  A_Z1,   A_ZERO, A_X1);
         7'd24: r = mk(U_END,  A_ZERO, A_ZERO, A_T0);
         7'd25: r = mk(U_MUL,  A_DT,   A_X1,   A_T0);
         7'd26: r = mk(U_MUL,  A_B0,   A_U0,   A_T1);
         7'd27: r = mk(U_MUL,  A_B0,   A_U1,   A_T2);
         7'd28: r = mk(U_ADD,  A_T1,   A_T2,   A_T1);
         7'd29: r = mk(U_ADD,  A_T0,   A_T1,   A_X0);
         7'd30: r = mk(U_MUL,  A_B2,   A_U0,   A_T1);
         7'd31: r = mk(U_MUL,  A_B2,   A_U1,   A_T2);
         7'd32: r = mk(U_ADD,  A_T1,   A_T2,   A_T1);
         7'd33: r = mk(U_ADD,  A_X1,   A_T1,   A_X1);
         7'd34: r = mk(U_MUL,  A_DT,   A_P3,   A_T0);
         7'd35: r = mk(U_MUL,  A_T0,   A_DT,   A_T1);
         7'd36: r = mk(U_ADD,  A_T1,   A_Q0,   A_P0);
         7'd37: r = mk(U_ADD,  A_T0,   A_Q1,   A_P1);
         7'd38: r = mk(U_ADD,  A_T0,   A_Q2,   A_P2);
         7'd39: r = mk(U_ADD,  A_P3,   A_Q3,   A_P3);
         7'd40: r = mk(U_ADD,  A_P0,   A_R0,   A_T2);
         7'd41: r = mk(U_ADD,  A_P1,   A_R1,   A_T3);
         7'd42: r = mk(U_ADD,  A_P2,   A_R1,   A_T4);
         7'd43: r = mk(U_ADD,  A_P3,   A_R3,   A_T5);
         7'd44: r = mk(U_MUL,  A_T2,   A_T5,   A_T6);
         7'd45: r = mk(U_MUL,  A_T3,   A_T4,   A_T7);
         7'd46: r = mk(U_SUB,  A_T6,   A_T7,   A_T6);
         7'd47: r = mk(U_BRZ,  A_T6,   A_ZERO, A_T0);
         7'd48: r = mk(U_DIVP, A_T5,   A_T6,   A_T8);
         7'd49: r = mk(U_DIVN, A_T3,   A_T6,   A_T9);
         7'd50: r = mk(U_DIVN, A_T4,   A_T6,   A_T10);
         7'd51: r = mk(U_DIVP, A_T2,   A_T6,   A_T11);
         7'd52: r = mk(U_MUL,  A_P0,   A_T8,   A_T0);
         7'd53: r = mk(U_MUL,  A_P1,   A_T10,  A_T1);
         7'd54: r = mk(U_ADD,  A_T0,   A_T1,   A_T12);
         7'd55: r = mk(U_MUL,  A_P0,   A_T9,   A_T0);
         7'd56: r = mk(U_MUL,  A_P1,   A_T11,  A_T1);
         7'd57: r = mk(U_ADD,  A_T0,   A_T1,   A_T13);
         7'd58: r = mk(U_MUL,  A_P2,   A_T8,   A_T0);
         7'd59: r = mk(U_MUL,  A_P3,   A_T10,  A_T1);
         7'd60: r = mk(U_ADD,  A_T0,   A_T1,   A_T14);
         7'd61: r = mk(U_MUL,  A_P2,   A_T9,   A_T0);
         7'd62: r = mk(U_MUL,  A_P3,   A_T11,  A_T1);
         7'd63: r = mk(U_ADD,  A_T0,   A_T1,   A_T15);
         7'd64: r = mk(U_SUB,  A_Z0,   A_X0,   A_T2);
         7'd65: r = mk(U_SUB,  A_Z1,   A_X1,   A_T3);
         7'd66: r = mk(U_MUL,  A_T12,  A_T2,   A_T0);
         7'd67: r = mk(U_MUL,  A_T13,  A_T3,   A_T1);
         7'd68: r = mk(U_ADD,  A_T0,   A_T1,   A_T4);
         7'd69: r = mk(U_ADD,  A_X0,   A_T4,   A_X0);
         7'd70: r = mk(U_MUL,  A_T14,  A_T2,   A_T0);
         7'd71: r = mk(U_MUL,  A_T15,  A_T3,   A_T1);
         7'd72: r = mk(U_ADD,  A_T0,   A_T1,   A_T4);
         7'd73: r = mk(U_ADD,  A_X1,   A_T4,   A_X1);
         7'd74: r = mk(U_MUL,  A_T12,  A_P0,   A_T0);
         7'd75: r = mk(U_MUL,  A_T13,  A_P2,   A_T1);
         7'd76: r = mk(U_ADD,  A_T0,   A_T1,   A_T4);
         7'd77: r = mk(U_MUL,  A_T12,  A_P1,   A_T0);
         7'd78: r = mk(U_MUL,  A_T13,  A_P3,   A_T1);
         7'd79: r = mk(U_ADD,  A_T0,   A_T1,   A_T5);
         7'd80: r = mk(U_MUL,  A_T14,  A_P0,   A_T0);
         7'd81: r = mk(U_MUL,  A_T15,  A_P2,   A_T1);
         7'd82: r = mk(U_ADD,  A_T0,   A_T1,   A_T6);
         7'd83: r = mk(U_MUL,  A_T14,  A_P1,   A_T0);
         7'd84: r = mk(U_MUL,  A_T15,  A_P3,   A_T1);
         7'd85: r = mk(U_ADD,  A_T0,   A_T1,   A_T7);
         7'd86: r = mk(U_SUB,  A_P0,   A_T4,   A_P0);
         7'd87: r = mk(U_SUB,  A_P1,   A_T5,   A_P1);
         7'd88: r = mk(U_SUB,  A_P2,   A_T6,   A_P2);
         7'd89: r = mk(U_SUB,  A_P3,   A_T7,   A_P3);
         default: r = mk(U_END, A_ZERO, A_ZERO, A_T0);
      endcase
      return r;
   endfunction

endpackage

@@ hdl/kalman_filter_2state_line_unit.sv @@
// Two-state (position, velocity) Kalman filter, signed Q16.16, saturating.
// One request beat in, one response beat out. Opcode 0 loads the noise model
// (B, Q, R) from time_step and slip_noise; opcode 1 runs predict and update
// and raises singular_flag when det(P+R) is zero (update skipped); opcode 2
// reloads the noise model with velocity_meas_noise, adds R into P and loads
// the state from the measurement; opcode 3 just returns the state. All work
// runs as a microprogram on one shared datapath: a 32x32 multiplier, a
// saturating adder and a bit-per-cycle restoring divider, fed from a 32-entry
// register file. Each micro-op reads its operands (S_READ) and executes
// (S_EXEC); a multiply writes back in S_MULW, a divide steps through S_DIV
// and writes back in S_DIVW. At the end of a beat the result is handed to
// the output register. req_stall is high while a beat is in work. The
// output register lets the next request beat be taken while a response is
// still waiting on rsp_stall. CSR writes are taken any time but must only be
// issued while the block is idle.
module kalman_filter_2state_line_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kf2_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kf2_pkg::rsp_type    rsp_data,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [30:0]         csr_wdata
);

   // sequencer
   kf2_pkg::state_type            state_ff, state_in;
   logic [kf2_pkg::PcW-1:0]       pc_ff, pc_in;
   kf2_pkg::instr_type            instr;

   // captured request
   logic [1:0]                    op_ff;
   logic [30:0]                   dt_ff;
   logic [30:0]                   th_ff;
   logic signed [31:0]            u0_ff, u1_ff, z0_ff, z1_ff;

   // csr
   logic [30:0]                   acc_ff;
   logic [30:0]                   vmn_ff;

   // register file
   logic signed [31:0]            mem [32];
   logic [31:0]                   vld_ff;
   logic                          mem_we;
   logic [4:0]                    wr_addr;
   logic signed [31:0]            wr_data;
   logic signed [31:0]            spec_a, spec_b;

   // datapath
   logic signed [31:0]            opa_ff, opb_ff;
   logic signed [63:0]            prod_ff;
   logic signed [31:0]            add_res, sub_res, mul_res, div_res;
   logic [kf2_pkg::NumW-1:0]      div_num_ff;
   logic [31:0]                   div_rem_ff;
   logic [31:0]                   div_den_ff;
   logic                          div_neg_ff;
   logic [kf2_pkg::DivCntW-1:0]   div_cnt_ff;
   logic [32:0]                   rem_shift;
   logic                          rem_ge;
   logic signed [32:0]            a_ext, b_ext, a_mag, b_mag;
   logic                          adj_neg;

   // state / result
   logic                          flag_ff;
   logic signed [31:0]            x0_ff, x1_ff;
   logic                          rsp_valid_ff;
   kf2_pkg::rsp_type              rsp_data_ff;
   logic                          req_take, rsp_load;

   assign instr    = kf2_pkg::prog_rom(pc_ff);
   assign req_take = req_valid && !req_stall;

   // fixed operand sources
   function automatic logic signed [31:0] pick_special(input logic [5:0] sel,
      input logic signed [31:0] u0, input logic signed [31:0] u1,
      input logic signed [31:0] z0, input logic signed [31:0] z1,
      input logic [30:0] th, input logic [30:0] dt, input logic [30:0] acc);
      logic signed [31:0] r;
      unique case (sel)
         kf2_pkg::A_ONE:  r = kf2_pkg::QOne;
         kf2_pkg::A_U0:   r = u0;
         kf2_pkg::A_U1:   r = u1;
         kf2_pkg::A_Z0:   r = z0;
         kf2_pkg::A_Z1:   r = z1;
         kf2_pkg::A_TH:   r = {1'b0, th};
         kf2_pkg::A_DTIN: r = {1'b0, dt};
         kf2_pkg::A_ACC:  r = {1'b0, acc};
         default:         r = '0;
      endcase
      return r;
   endfunction

   assign spec_a = pick_special(instr.src_a, u0_ff, u1_ff, z0_ff, z1_ff, th_ff, dt_ff, acc_ff);
   assign spec_b = pick_special(instr.src_b, u0_ff, u1_ff, z0_ff, z1_ff, th_ff, dt_ff, acc_ff);

   // ALU
   assign add_res = kf2_pkg::sat32(64'(opa_ff) + 64'(opb_ff));
   assign sub_res = kf2_pkg::sat32(64'(opa_ff) - 64'(opb_ff));
   // mulq: floor shift of the registered product
   assign mul_res = kf2_pkg::sat32(prod_ff >>> kf2_pkg::FracBits);

   // divider setup: magnitudes and result sign
   assign a_ext   = 33'(opa_ff);
   assign b_ext   = 33'(opb_ff);
   assign a_mag   = opa_ff[31] ? -a_ext : a_ext;
   assign b_mag   = opb_ff[31] ? -b_ext : b_ext;
   assign adj_neg = (instr.uop == kf2_pkg::U_DIVN) ? (opa_ff > 32'sd0) : opa_ff[31];

   // one restoring step per cycle
   assign rem_shift = {div_rem_ff, div_num_ff[kf2_pkg::NumW-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_den_ff};

   // truncated quotient, signed and saturated
   always_comb begin
      if (!div_neg_ff) begin
         if (div_num_ff > {{kf2_pkg::FracBits{1'b0}}, 32'h7FFF_FFFF}) div_res = kf2_pkg::MaxPos;
         else div_res = div_num_ff[31:0];
      end else begin
         if (div_num_ff > {{kf2_pkg::FracBits{1'b0}}, 32'h8000_0000}) div_res = kf2_pkg::MinNeg;
         else div_res = -div_num_ff[31:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      unique case (state_ff)
         kf2_pkg::S_IDLE: begin
            if (req_valid) begin
               pc_in    = (req_data.opcode == kf2_pkg::OpFull) ? kf2_pkg::PcFull
                                                               : kf2_pkg::PcNoise;
               state_in = (req_data.opcode == kf2_pkg::OpNone) ? kf2_pkg::S_DONE
                                                               : kf2_pkg::S_READ;
            end
         end
         kf2_pkg::S_READ: state_in = kf2_pkg::S_EXEC;
         kf2_pkg::S_EXEC: begin
            case (instr.uop) inside
               kf2_pkg::U_MUL: state_in = kf2_pkg::S_MULW;
               kf2_pkg::U_DIVP, kf2_pkg::U_DIVN: state_in = kf2_pkg::S_DIV;
               kf2_pkg::U_END: state_in = kf2_pkg::S_DONE;
               kf2_pkg::U_BRZ: begin
                  if (opa_ff == 32'sd0) begin
                     state_in = kf2_pkg::S_DONE;
                  end else begin
                     state_in = kf2_pkg::S_READ;
                     pc_in    = pc_ff + 1'b1;
                  end
               end
               kf2_pkg::U_RET: begin
                  if (op_ff == kf2_pkg::OpNoise) begin
                     state_in = kf2_pkg::S_DONE;
                  end else begin
                     state_in = kf2_pkg::S_READ;
                     pc_in    = pc_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = kf2_pkg::S_READ;
                  pc_in    = pc_ff + 1'b1;
               end
            endcase
         end
         kf2_pkg::S_MULW, kf2_pkg::S_DIVW: begin
            state_in = kf2_pkg::S_READ;
            pc_in    = pc_ff + 1'b1;
         end
         kf2_pkg::S_DIV: begin
            if (div_cnt_ff == kf2_pkg::DivCntW'(kf2_pkg::NumW - 1)) state_in = kf2_pkg::S_DIVW;
         end
         kf2_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = kf2_pkg::S_IDLE;
         end
         default: state_in = kf2_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = (state_ff != kf2_pkg::S_IDLE);
      rsp_load  = (state_ff == kf2_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);
      mem_we    = 1'b0;
      wr_addr   = instr.dst;
      wr_data   = add_res;
      unique case (state_ff)
         kf2_pkg::S_EXEC: begin
            case (instr.uop) inside
               kf2_pkg::U_ADD: begin
                  mem_we  = 1'b1;
                  wr_data = add_res;
               end
               kf2_pkg::U_SUB: begin
                  mem_we  = 1'b1;
                  wr_data = sub_res;
               end
               kf2_pkg::U_SHR1: begin
                  mem_we  = 1'b1;
                  wr_data = opa_ff >>> 1;
               end
               kf2_pkg::U_SHR2: begin
                  mem_we  = 1'b1;
                  wr_data = opa_ff >>> 2;
               end
               default: mem_we = 1'b0;
            endcase
         end
         kf2_pkg::S_MULW: begin
            mem_we  = 1'b1;
            wr_data = mul_res;
         end
         kf2_pkg::S_DIVW: begin
            mem_we  = 1'b1;
            wr_data = div_res;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kf2_pkg::S_IDLE;
         pc_ff        <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         x0_ff        <= '0;
         x1_ff        <= '0;
         acc_ff       <= 31'(kf2_pkg::QOne);
         vmn_ff       <= 31'(kf2_pkg::QOne);
         div_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (req_take) flag_ff <= 1'b0;
         else if (state_ff == kf2_pkg::S_EXEC && instr.uop == kf2_pkg::U_BRZ
                  && opa_ff == 32'sd0) flag_ff <= 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (mem_we) begin
            vld_ff[wr_addr] <= 1'b1;
            if (wr_addr == kf2_pkg::A_X0[4:0]) x0_ff <= wr_data;
            if (wr_addr == kf2_pkg::A_X1[4:0]) x1_ff <= wr_data;
         end
         if (csr_we) begin
            if (csr_index == kf2_pkg::CsrAccel) acc_ff <= csr_wdata;
            if (csr_index == kf2_pkg::CsrVmeas) vmn_ff <= csr_wdata;
         end
         if (state_ff == kf2_pkg::S_EXEC) div_cnt_ff <= '0;
         else if (state_ff == kf2_pkg::S_DIV) div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // request capture, register file, datapath
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_data.opcode;
         dt_ff <= req_data.time_step;
         th_ff <= (req_data.opcode == kf2_pkg::OpMeas) ? vmn_ff : req_data.slip_noise;
         u0_ff <= req_data.ctrl_u0;
         u1_ff <= req_data.ctrl_u1;
         z0_ff <= req_data.meas_z0;
         z1_ff <= req_data.meas_z1;
      end
      if (mem_we) mem[wr_addr] <= wr_data;
      if (state_ff == kf2_pkg::S_READ) begin
         opa_ff <= instr.src_a[5] ? spec_a
                   : (vld_ff[instr.src_a[4:0]] ? mem[instr.src_a[4:0]] : 32'sd0);
         opb_ff <= instr.src_b[5] ? spec_b
                   : (vld_ff[instr.src_b[4:0]] ? mem[instr.src_b[4:0]] : 32'sd0);
      end
      if (state_ff == kf2_pkg::S_EXEC) begin
         prod_ff    <= opa_ff * opb_ff;
         div_num_ff <= {a_mag[31:0], {kf2_pkg::FracBits{1'b0}}};
         div_den_ff <= b_mag[31:0];
         div_rem_ff <= '0;
         div_neg_ff <= adj_neg ^ opb_ff[31];
      end else if (state_ff == kf2_pkg::S_DIV) begin
         div_rem_ff <= rem_ge ? 32'(rem_shift - {1'b0, div_den_ff}) : rem_shift[31:0];
         div_num_ff <= {div_num_ff[kf2_pkg::NumW-2:0], rem_ge};
      end
      if (rsp_load) begin
         rsp_data_ff.est_x0        <= x0_ff;
         rsp_data_ff.est_x1        <= x1_ff;
         rsp_data_ff.singular_flag <= flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted beat always starts work
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != kf2_pkg::S_IDLE)
      else $error("accepted beat did not start");

   // singular flag only comes out of a full step
   a_flag_full: assert property (@(posedge clock) disable iff (reset)
      rsp_load && flag_ff |-> op_ff == kf2_pkg::OpFull)
      else $error("singular flag on non-update opcode");

   // divider never overruns its bit count
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == kf2_pkg::S_DIV |-> div_cnt_ff < kf2_pkg::DivCntW'(kf2_pkg::NumW))
      else $error("divider count overrun");

   // register file is only written while a beat is in work
   a_we_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != kf2_pkg::S_IDLE && state_ff != kf2_pkg::S_DONE)
      else $error("register file write while idle");

endmodule

@@ dv/kalman_filter_2state_line_unit_tb.sv @@
module kalman_filter_2state_line_unit_tb;

   typedef logic signed [31:0] mat_type [4];

   // run stops here no matter what
   localparam int CycleLimit = 4_000_000;
   // settle time after the last response
   localparam int Drain = 600;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   kf2_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   kf2_pkg::rsp_type  rsp_data;
   logic              csr_we = 1'b0;
   logic [0:0]        csr_index = kf2_pkg::CsrAccel;
   logic [30:0]       csr_wdata = '0;

   kalman_filter_2state_line_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // filter state as the testbench tracks it
   logic [30:0]        acc_var  = 31'd65536;
   logic [30:0]        vel_var  = 31'd65536;
   logic signed [31:0] est_pos, est_vel, step_dt;
   mat_type            cov, gain_b, q_noise, r_noise;

   kf2_pkg::req_type  pending_beats [$];
   kf2_pkg::rsp_type  expected_estimates [$];
   int       mismatches = 0;
   int       cycles = 0;
   bit       calm = 1'b0;   // no idling on either side while set

   function automatic logic signed [31:0] clip(input longint v);
      if (v > longint'(kf2_pkg::MaxPos)) return kf2_pkg::MaxPos;
      if (v < longint'(kf2_pkg::MinNeg)) return kf2_pkg::MinNeg;
      return v[31:0];
   endfunction

   // fixed-point product, floor rounding
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clip(p >>> kf2_pkg::FracBits);
   endfunction

   function automatic logic signed [31:0] dot2(input logic signed [31:0] a0,
         input logic signed [31:0] b0, input logic signed [31:0] a1,
         input logic signed [31:0] b1);
      return clip(longint'(qmul(a0, b0)) + longint'(qmul(a1, b1)));
   endfunction

   // a*b, or a*b' when trans is set
   function automatic mat_type mat_prod(input mat_type a, input mat_type b,
                                        input bit trans);
      mat_type r;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            r[i*2+j] = trans ? dot2(a[i*2], b[j*2], a[i*2+1], b[j*2+1])
                             : dot2(a[i*2], b[j], a[i*2+1], b[2+j]);
      return r;
   endfunction

   function automatic void load_noise(input logic signed [31:0] dt,
                                      input logic signed [31:0] theta);
      logic signed [31:0] r3, b0, b1;
      mat_type d, t;
      r3 = qmul(theta, theta);
      step_dt = dt;
      b0 = qmul(dt, dt) / 4;
      b1 = dt / 2;
      gain_b = '{b0, b0, b1, b1};
      d = '{{1'b0, acc_var}, 32'sd0, 32'sd0, {1'b0, acc_var}};
      t = mat_prod(gain_b, d, 1'b0);
      q_noise = mat_prod(t, gain_b, 1'b1);
      r_noise[3] = r3;
      r_noise[1] = qmul(r3, dt);
      r_noise[2] = r_noise[1];
      r_noise[0] = qmul(r_noise[1], dt);
   endfunction

   function automatic kf2_pkg::rsp_type kalman_step(input kf2_pkg::req_type rq);
      kf2_pkg::rsp_type   rs;
      mat_type            a, t, s, inv, k;
      logic signed [31:0] n0, n1, det, d0, d1;
      longint             adj [4];
      rs.singular_flag = 1'b0;
      case (rq.opcode)
         kf2_pkg::OpNoise: load_noise({1'b0, rq.time_step}, {1'b0, rq.slip_noise});
         kf2_pkg::OpFull: begin
            // predict
            a = '{32'sd0, step_dt, 32'sd0, kf2_pkg::QOne};
            n0 = clip(longint'(dot2(a[0], est_pos, a[1], est_vel))
                      + dot2(gain_b[0], rq.ctrl_u0, gain_b[1], rq.ctrl_u1));
            n1 = clip(longint'(dot2(a[2], est_pos, a[3], est_vel))
                      + dot2(gain_b[2], rq.ctrl_u0, gain_b[3], rq.ctrl_u1));
            est_pos = n0;
            est_vel = n1;
            t = mat_prod(a, cov, 1'b0);
            t = mat_prod(t, a, 1'b1);
            for (int i = 0; i < 4; i++) cov[i] = clip(longint'(t[i]) + q_noise[i]);
            for (int i = 0; i < 4; i++) s[i] = clip(longint'(cov[i]) + r_noise[i]);
            det = clip(longint'(qmul(s[0], s[3])) - qmul(s[1], s[2]));
            if (det == 0) begin
               // singular innovation covariance: keep the prediction
               rs.singular_flag = 1'b1;
            end else begin
               adj[0] = s[3];
               adj[1] = -longint'(s[1]);
               adj[2] = -longint'(s[2]);
               adj[3] = s[0];
               for (int i = 0; i < 4; i++)
                  inv[i] = clip((adj[i] * (longint'(1) << kf2_pkg::FracBits))
                                / longint'(det));
               k = mat_prod(cov, inv, 1'b0);
               d0 = clip(longint'(rq.meas_z0) - est_pos);
               d1 = clip(longint'(rq.meas_z1) - est_vel);
               n0 = clip(longint'(est_pos) + dot2(k[0], d0, k[1], d1));
               n1 = clip(longint'(est_vel) + dot2(k[2], d0, k[3], d1));
               est_pos = n0;
               est_vel = n1;
               t = mat_prod(k, cov, 1'b0);
               for (int i = 0; i < 4; i++) cov[i] = clip(longint'(cov[i]) - t[i]);
            end
         end
         kf2_pkg::OpMeas: begin
            load_noise({1'b0, rq.time_step}, {1'b0, vel_var});
            for (int i = 0; i < 4; i++) cov[i] = clip(longint'(cov[i]) + r_noise[i]);
            est_pos = rq.meas_z0;
            est_vel = rq.meas_z1;
         end
         default: ;  // unused opcode leaves everything alone
      endcase
      rs.est_x0 = est_pos;
      rs.est_x1 = est_vel;
      return rs;
   endfunction

   // request driver: one beat in flight, payload held while stalled
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_estimates.push_back(kalman_step(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
               req_data  <= pending_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_estimates.size() == 0) begin
               $error("response beat with nothing expected: x0=%0d x1=%0d",
                      rsp_data.est_x0, rsp_data.est_x1);
               mismatches++;
            end else begin
               kf2_pkg::rsp_type e;
               e = expected_estimates.pop_front();
               if (rsp_data.est_x0 !== e.est_x0) begin
                  $error("est_x0 expected %0d actual %0d", e.est_x0, rsp_data.est_x0);
                  mismatches++;
               end
               if (rsp_data.est_x1 !== e.est_x1) begin
                  $error("est_x1 expected %0d actual %0d", e.est_x1, rsp_data.est_x1);
                  mismatches++;
               end
               if (rsp_data.singular_flag !== e.singular_flag) begin
                  $error("singular_flag expected %0b actual %0b",
                         e.singular_flag, rsp_data.singular_flag);
                  mismatches++;
               end
            end
         end
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [30:0] pick_u31();
      case ($urandom_range(7))
         0, 1, 2: return 31'($urandom_range(0, 131072));   // up to 2.0
         3:       return 31'($urandom_range(0, 1024));     // tiny
         4:       return '1;
         5:       return '0;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_s32();
      case ($urandom_range(7))
         0, 1, 2, 3: return 32'($urandom_range(0, 1 << 22)) - 32'sd2097152;
         4:          return kf2_pkg::MaxPos;
         5:          return kf2_pkg::MinNeg;
         default:    return 32'($urandom);
      endcase
   endfunction

   function automatic kf2_pkg::req_type random_beat();
      kf2_pkg::req_type r;
      int      w;
      w = $urandom_range(99);
      // mostly filter steps; unused opcode stays rare
      r.opcode     = (w < 10) ? kf2_pkg::OpNoise : (w < 75) ? kf2_pkg::OpFull
                   : (w < 93) ? kf2_pkg::OpMeas : kf2_pkg::OpNone;
      r.time_step  = pick_u31();
      r.slip_noise = pick_u31();
      r.ctrl_u0    = pick_s32();
      r.ctrl_u1    = pick_s32();
      r.meas_z0    = pick_s32();
      r.meas_z1    = pick_s32();
      return r;
   endfunction

   function automatic kf2_pkg::req_type beat(input logic [1:0] op, input logic [30:0] dt,
         input logic [30:0] th, input logic signed [31:0] u0,
         input logic signed [31:0] u1, input logic signed [31:0] z0,
         input logic signed [31:0] z1);
      kf2_pkg::req_type r;
      r = '{op, dt, th, u0, u1, z0, z1};
      return r;
   endfunction

   // block until every queued beat went in and every response came back
   task automatic drain_all();
      while (pending_beats.size() > 0 || req_valid || expected_estimates.size() > 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [30:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == kf2_pkg::CsrAccel) acc_var = val;
      else vel_var = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) pending_beats.push_back(random_beat());
      drain_all();
   endtask

   initial begin
      est_pos = '0; est_vel = '0; step_dt = '0;
      cov = '{default: '0}; gain_b = '{default: '0};
      q_noise = '{default: '0}; r_noise = '{default: '0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: fresh state is singular, then extremes of every field
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'd65536, 31'd0, 32'sd65536, 32'sd0,
                                   32'sd100, 32'sd5));
      pending_beats.push_back(beat(kf2_pkg::OpNone, '1, '1, kf2_pkg::MaxPos,
                                   kf2_pkg::MinNeg, kf2_pkg::MaxPos, kf2_pkg::MinNeg));
      pending_beats.push_back(beat(kf2_pkg::OpNoise, 31'd65536, 31'd65536, 0, 0, 0, 0));
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'd65536, 31'd0, 32'sd65536,
                                   -32'sd65536, 32'sd131072, -32'sd65536));
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'd6554, '1, kf2_pkg::MaxPos,
                                   kf2_pkg::MaxPos, kf2_pkg::MinNeg, kf2_pkg::MaxPos));
      pending_beats.push_back(beat(kf2_pkg::OpMeas, 31'd32768, 31'd0, 0, 0, 32'sd1000,
                                   -32'sd1000));
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'd0, 31'd0, kf2_pkg::MinNeg,
                                   kf2_pkg::MinNeg, kf2_pkg::MaxPos, kf2_pkg::MinNeg));
      pending_beats.push_back(beat(kf2_pkg::OpNoise, '1, '1, kf2_pkg::MaxPos,
                                   kf2_pkg::MinNeg, kf2_pkg::MaxPos, kf2_pkg::MinNeg));
      pending_beats.push_back(beat(kf2_pkg::OpFull, '1, '1, kf2_pkg::MaxPos,
                                   kf2_pkg::MaxPos, kf2_pkg::MinNeg, kf2_pkg::MinNeg));
      pending_beats.push_back(beat(kf2_pkg::OpMeas, '1, '1, kf2_pkg::MinNeg,
                                   kf2_pkg::MaxPos, kf2_pkg::MinNeg, kf2_pkg::MaxPos));
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'd0, 31'd0, 0, 0, 0, 0));
      pending_beats.push_back(beat(kf2_pkg::OpNoise, 31'd0, 31'd0, 0, 0, 0, 0));
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'd0, 31'd0, 32'sd1, 32'sd1, 32'sd7,
                                   -32'sd7));
      pending_beats.push_back(beat(kf2_pkg::OpNoise, 31'd1, 31'd1, 0, 0, 0, 0));
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'd1, 31'd1, -32'sd1, 32'sd1, 32'sd3,
                                   32'sd3));
      pending_beats.push_back(beat(kf2_pkg::OpMeas, 31'd0, 31'd0, -32'sd1, -32'sd1,
                                   -32'sd1, -32'sd1));
      pending_beats.push_back(beat(kf2_pkg::OpNoise, 31'h2AAA_AAAA, 31'h5555_5555,
                                   0, 0, 0, 0));
      pending_beats.push_back(beat(kf2_pkg::OpFull, 31'h5555_5555, 31'h2AAA_AAAA,
                                   32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                                   32'sh5555_5555));
      pending_beats.push_back(beat(kf2_pkg::OpNone, 31'd0, 31'd0, 0, 0, 0, 0));
      drain_all();   // sender holds off until every response is back

      // no process noise, loudest measurement noise
      csr_write(kf2_pkg::CsrAccel, 31'd0);
      csr_write(kf2_pkg::CsrVmeas, '1);
      random_phase(150);

      // loudest process noise, silent measurement; no idling in this stretch
      csr_write(kf2_pkg::CsrAccel, '1);
      csr_write(kf2_pkg::CsrVmeas, 31'd0);
      calm = 1'b1;
      random_phase(150);
      calm = 1'b0;

      csr_write(kf2_pkg::CsrAccel, 31'd65536);
      csr_write(kf2_pkg::CsrVmeas, 31'($urandom_range(0, 262144)));
      random_phase(150);

      csr_write(kf2_pkg::CsrAccel, 31'($urandom));
      csr_write(kf2_pkg::CsrVmeas, 31'($urandom));
      random_phase(150);

      repeat (Drain) @(posedge clock);
      if (expected_estimates.size() > 0) begin
         $error("%0d expected responses never arrived", expected_estimates.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/kf2_pkg.sv
hdl/kalman_filter_2state_line_unit.sv
dv/kalman_filter_2state_line_unit_tb.sv
